// ----- sv/jti_pkg.sv -----
package jti_pkg;

    // Angle and tick widths of the datapath.
    localparam int ANGLE_W = 16;
    localparam int TICK_W  = 16;

    // Magnitude of a joint distance and width of every quotient.
    localparam int QUOT_W = ANGLE_W + 1;
    // Width of a product of a magnitude and a tick count.
    localparam int PROD_W = QUOT_W + TICK_W;
    localparam int CNT_W  = $clog2(QUOT_W);

    // Stream payload layout.
    localparam int IN_BITS    = 2 + 3 * ANGLE_W + TICK_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 3 * ANGLE_W + 3;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_J2_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_J2_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_J3_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_J3_HIGH = 2'd3;

    // Reset values of the joint limits.
    localparam logic signed [ANGLE_W-1:0] J2_LOW_RESET  = ANGLE_W'(-16036);
    localparam logic signed [ANGLE_W-1:0] J2_HIGH_RESET = ANGLE_W'(3174);
    localparam logic signed [ANGLE_W-1:0] J3_LOW_RESET  = ANGLE_W'(-9687);
    localparam logic signed [ANGLE_W-1:0] J3_HIGH_RESET = ANGLE_W'(9687);

    // Item kinds.
    localparam logic FUNC_MOVE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Interpolation types.
    localparam logic [1:0] INTERP_LINEAR = 2'd1;
    localparam logic [1:0] INTERP_BLEND  = 2'd2;

    // Result status codes.
    localparam logic [2:0] STAT_HOLD     = 3'd0;
    localparam logic [2:0] STAT_MOVING   = 3'd1;
    localparam logic [2:0] STAT_FINISHED = 3'd2;
    localparam logic [2:0] STAT_BAD      = 3'd3;
    localparam logic [2:0] STAT_BUSY     = 3'd4;

    // Request to the shared multiply-divide unit: x * y / t.
    typedef struct packed {
        logic              start;
        logic [QUOT_W-1:0] x;
        logic [TICK_W-1:0] y;
        logic [TICK_W-1:0] t;
    } md_req_t;

    // Response: floor and rounded quotient, valid while done is high.
    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
        logic [QUOT_W-1:0] quot_rnd;
    } md_rsp_t;

endpackage

// ----- sv/jti_muldiv.sv -----
module jti_muldiv (
    input  logic             aclk,
    input  logic             aresetn,
    input  jti_pkg::md_req_t req,
    output jti_pkg::md_rsp_t rsp
);

    typedef enum logic [1:0] {
        M_IDLE,
        M_MUL,
        M_DIV
    } md_state_t;

    md_state_t                       state_reg;
    logic [jti_pkg::QUOT_W-1:0]      x_reg;
    logic [jti_pkg::TICK_W-1:0]      y_reg;
    logic [jti_pkg::TICK_W-1:0]      t_reg;
    logic [jti_pkg::TICK_W-1:0]      rem_reg;
    logic [jti_pkg::QUOT_W-1:0]      q_reg;
    logic [jti_pkg::CNT_W-1:0]       cnt_reg;
    logic                            done_reg;

    logic [jti_pkg::PROD_W-1:0]      prod;
    logic [jti_pkg::TICK_W:0]        trial;
    logic [jti_pkg::TICK_W:0]        diff;
    logic                            ge;
    logic                            round_up;

    // The product is registered before the divide starts.
    assign prod = jti_pkg::PROD_W'(x_reg) * jti_pkg::PROD_W'(y_reg);

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign trial = {rem_reg, q_reg[jti_pkg::QUOT_W-1]};
    assign diff  = trial - {1'b0, t_reg};
    assign ge    = (trial >= {1'b0, t_reg});

    // Round to nearest, ties up: twice the remainder against the divisor.
    assign round_up = ({rem_reg, 1'b0} >= {1'b0, t_reg});

    assign rsp.done     = done_reg;
    assign rsp.quot     = q_reg;
    assign rsp.quot_rnd = q_reg + jti_pkg::QUOT_W'(round_up);

    // Sequencer of the multiply and the bit-serial divide. The quotient is
    // known to fit QUOT_W bits, so the upper product bits seed the remainder.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                M_IDLE: begin
                    done_reg <= 1'b0;
                    if (req.start) begin
                        x_reg     <= req.x;
                        y_reg     <= req.y;
                        t_reg     <= req.t;
                        state_reg <= M_MUL;
                    end
                end
                M_MUL: begin
                    rem_reg   <= prod[jti_pkg::PROD_W-1:jti_pkg::QUOT_W];
                    q_reg     <= prod[jti_pkg::QUOT_W-1:0];
                    cnt_reg   <= '0;
                    state_reg <= M_DIV;
                end
                M_DIV: begin
                    rem_reg <= ge ? diff[jti_pkg::TICK_W-1:0] : trial[jti_pkg::TICK_W-1:0];
                    q_reg   <= {q_reg[jti_pkg::QUOT_W-2:0], ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == jti_pkg::CNT_W'(jti_pkg::QUOT_W - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= M_IDLE;
                    end
                end
                default: begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- sv/joint_trajectory_interpolator_unit.sv -----
// Channel   | Direction | Transfer contents
// ----------+-----------+---------------------------------------------------
// s_axis    | in        | one move command or one tick (kind in tuser)
// m_axis    | out       | three joint setpoints and a status, one per input
// cfg       | in        | write of one joint limit register
//
// Holding, rejected, accepted-move and move-finished results go from the input
// transfer straight to the output stage. A busy reply or a tick inside a move runs each
// joint through the shared multiply and one-bit-per-cycle divider, once per
// joint for a linear move and twice for a blend.
// Reset is synchronous and active low; it clears the move state and restores
// the limits. A stalled result holds the next result in S_EMIT and the input not ready.
module joint_trajectory_interpolator_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // interp_type, goal1, goal2, goal3, move_ticks, zero fill
    input  logic [jti_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // func
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // setpoint1, setpoint2, setpoint3, status, zero fill
    output logic [jti_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [jti_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [jti_pkg::ANGLE_W-1:0]         cfg_data
);

    localparam int A  = jti_pkg::ANGLE_W;
    localparam int TW = jti_pkg::TICK_W;
    localparam int QW = jti_pkg::QUOT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAUNCH1,
        S_WAIT1,
        S_LAUNCH2,
        S_WAIT2,
        S_EMIT
    } seq_state_t;

    seq_state_t                  state_reg;
    logic [1:0]                  joint_reg;
    logic signed [A-1:0]         start_reg [3];
    logic signed [A-1:0]         goal_reg [3];
    logic signed [A-1:0]         sp_reg [3];
    logic [TW-1:0]               elapsed_reg;
    logic [TW-1:0]               span_reg;
    logic                        blend_reg;
    logic                        moving_reg;
    logic [2:0]                  status_reg;
    logic [QW-1:0]               a_reg;
    logic signed [A-1:0]         lim_reg [4];
    logic                        m_valid_reg;
    logic [jti_pkg::OUT_DATA_W-1:0] out_data_reg;

    // Input fields.
    logic                        in_func;
    logic [1:0]                  in_type;
    logic signed [A-1:0]         in_goal1;
    logic signed [A-1:0]         in_goal2;
    logic signed [A-1:0]         in_goal3;
    logic [TW-1:0]               in_ticks;
    logic                        in_xfer;
    logic                        bad_move;
    logic [TW-1:0]               elapsed_inc;
    logic                        emit_fire;

    // Per-joint datapath.
    logic signed [A-1:0]         cur_s;
    logic signed [A-1:0]         cur_g;
    logic signed [A:0]           delta;
    logic                        neg;
    logic [QW-1:0]               mag;
    logic                        first_half;
    logic [TW-1:0]               u_val;
    logic                        from_start;
    logic                        add_q;
    logic signed [A:0]           base_x;
    logic [A:0]                  p_wide;
    logic [A-1:0]                point;

    jti_pkg::md_req_t            md_req;
    jti_pkg::md_rsp_t            md_rsp;

    assign in_func  = s_axis_tuser[0];
    assign in_type  = s_axis_tdata[1:0];
    assign in_goal1 = s_axis_tdata[2 +: A];
    assign in_goal2 = s_axis_tdata[2 + A +: A];
    assign in_goal3 = s_axis_tdata[2 + 2 * A +: A];
    assign in_ticks = s_axis_tdata[2 + 3 * A +: TW];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A finished result moves into the output register once it is free.
    assign emit_fire = (state_reg == S_EMIT) && (!m_valid_reg || m_axis_tready);

    // Move checks: known type, joints 2 and 3 within limits, nonzero length.
    assign bad_move = !(in_type == jti_pkg::INTERP_LINEAR || in_type == jti_pkg::INTERP_BLEND)
                   || (in_goal2 < lim_reg[jti_pkg::REG_J2_LOW])
                   || (in_goal2 > lim_reg[jti_pkg::REG_J2_HIGH])
                   || (in_goal3 < lim_reg[jti_pkg::REG_J3_LOW])
                   || (in_goal3 > lim_reg[jti_pkg::REG_J3_HIGH])
                   || (in_ticks == '0);

    assign elapsed_inc = elapsed_reg + 1'b1;

    // Distance and magnitude of the joint under work.
    assign cur_s = start_reg[joint_reg];
    assign cur_g = goal_reg[joint_reg];
    assign delta = {cur_g[A-1], cur_g} - {cur_s[A-1], cur_s};
    assign neg   = delta[A];
    assign mag   = neg ? QW'(-delta) : QW'(delta);

    // The blend runs forward from the start in the first half and backward
    // from the goal in the second.
    assign first_half = ({elapsed_reg, 1'b0} <= {1'b0, span_reg});
    assign u_val      = first_half ? elapsed_reg : span_reg - elapsed_reg;
    assign from_start = !blend_reg || first_half;
    assign add_q      = from_start ? !neg : neg;
    assign base_x     = from_start ? {cur_s[A-1], cur_s} : {cur_g[A-1], cur_g};
    assign p_wide     = add_q ? base_x + md_rsp.quot_rnd : base_x - md_rsp.quot_rnd;
    assign point      = p_wide[A-1:0];

    // Operands for the shared unit.
    always_comb begin
        md_req.start = (state_reg == S_LAUNCH1) || (state_reg == S_LAUNCH2);
        md_req.t     = span_reg;
        if (state_reg == S_LAUNCH2) begin
            md_req.x = {a_reg[QW-2:0], 1'b0};
            md_req.y = u_val;
        end else begin
            md_req.x = mag;
            md_req.y = blend_reg ? u_val : elapsed_reg;
        end
    end

    jti_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .rsp     (md_rsp)
    );

    // Limit registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg[jti_pkg::REG_J2_LOW]  <= jti_pkg::J2_LOW_RESET;
            lim_reg[jti_pkg::REG_J2_HIGH] <= jti_pkg::J2_HIGH_RESET;
            lim_reg[jti_pkg::REG_J3_LOW]  <= jti_pkg::J3_LOW_RESET;
            lim_reg[jti_pkg::REG_J3_HIGH] <= jti_pkg::J3_HIGH_RESET;
        end else if (cfg_we) begin
            lim_reg[cfg_index] <= cfg_data;
        end
    end

    // Sequencer, move state and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            joint_reg   <= '0;
            elapsed_reg <= '0;
            span_reg    <= '0;
            blend_reg   <= 1'b0;
            moving_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int j = 0; j < 3; j++) begin
                start_reg[j] <= '0;
                goal_reg[j]  <= '0;
            end
        end else begin
            // Output valid rises with a new result and falls when it is taken.
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_xfer) begin
                        joint_reg <= '0;
                        if (in_func == jti_pkg::FUNC_MOVE) begin
                            for (int j = 0; j < 3; j++) begin
                                sp_reg[j] <= start_reg[j];
                            end
                            if (moving_reg) begin
                                status_reg <= jti_pkg::STAT_BUSY;
                                state_reg  <= S_LAUNCH1;
                            end else if (bad_move) begin
                                status_reg <= jti_pkg::STAT_BAD;
                                state_reg  <= S_EMIT;
                            end else begin
                                goal_reg[0] <= in_goal1;
                                goal_reg[1] <= in_goal2;
                                goal_reg[2] <= in_goal3;
                                span_reg    <= in_ticks;
                                elapsed_reg <= '0;
                                blend_reg   <= (in_type == jti_pkg::INTERP_BLEND);
                                moving_reg  <= 1'b1;
                                status_reg  <= jti_pkg::STAT_MOVING;
                                state_reg   <= S_EMIT;
                            end
                        end else if (!moving_reg) begin
                            for (int j = 0; j < 3; j++) begin
                                sp_reg[j] <= start_reg[j];
                            end
                            status_reg <= jti_pkg::STAT_HOLD;
                            state_reg  <= S_EMIT;
                        end else if (elapsed_inc == span_reg) begin
                            // Last tick lands on the goal, which becomes the held position.
                            for (int j = 0; j < 3; j++) begin
                                start_reg[j] <= goal_reg[j];
                                sp_reg[j]    <= goal_reg[j];
                            end
                            moving_reg  <= 1'b0;
                            elapsed_reg <= '0;
                            status_reg  <= jti_pkg::STAT_FINISHED;
                            state_reg   <= S_EMIT;
                        end else begin
                            elapsed_reg <= elapsed_inc;
                            status_reg  <= jti_pkg::STAT_MOVING;
                            state_reg   <= S_LAUNCH1;
                        end
                    end
                end
                S_LAUNCH1: begin
                    state_reg <= S_WAIT1;
                end
                S_WAIT1: begin
                    if (md_rsp.done) begin
                        if (blend_reg) begin
                            a_reg     <= md_rsp.quot;
                            state_reg <= S_LAUNCH2;
                        end else begin
                            sp_reg[joint_reg] <= point;
                            joint_reg         <= joint_reg + 1'b1;
                            state_reg         <= (joint_reg == 2'd2) ? S_EMIT : S_LAUNCH1;
                        end
                    end
                end
                S_LAUNCH2: begin
                    state_reg <= S_WAIT2;
                end
                S_WAIT2: begin
                    if (md_rsp.done) begin
                        sp_reg[joint_reg] <= point;
                        joint_reg         <= joint_reg + 1'b1;
                        state_reg         <= (joint_reg == 2'd2) ? S_EMIT : S_LAUNCH1;
                    end
                end
                S_EMIT: begin
                    if (emit_fire) begin
                        out_data_reg <= jti_pkg::OUT_DATA_W'({status_reg, sp_reg[2],
                                                              sp_reg[1], sp_reg[0]});
                        joint_reg    <= '0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The divider reports only while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        md_rsp.done |-> (state_reg == S_WAIT1 || state_reg == S_WAIT2))
        else $error("divider result outside a wait state");

    // A running move always has time left.
    assert property (@(posedge aclk) disable iff (!aresetn)
        moving_reg |-> (span_reg != '0) && (elapsed_reg < span_reg))
        else $error("move elapsed count out of range");

    // A tick while holding needs no arithmetic.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && (in_func == jti_pkg::FUNC_TICK) && !moving_reg |=> state_reg == S_EMIT)
        else $error("holding tick did not go straight to output");

    // Only three joints are worked.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE && state_reg != S_EMIT) |-> joint_reg != 2'd3)
        else $error("joint index out of range");

endmodule

// ----- dv/testbench.sv -----
module testbench;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 8;
    localparam int SETTLE_CYCLES   = 8;
    localparam int END_CYCLES      = 200;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int REPORT_LIMIT    = 10;

    // Interpolation codes that the block must reject.
    localparam logic [1:0] INTERP_NONE = 2'd0;
    localparam logic [1:0] INTERP_RSVD = 2'd3;

    // Input payload, first field in the lowest bits.
    typedef struct packed {
        logic [jti_pkg::TICK_W-1:0]         ticks;
        logic signed [jti_pkg::ANGLE_W-1:0] goal3;
        logic signed [jti_pkg::ANGLE_W-1:0] goal2;
        logic signed [jti_pkg::ANGLE_W-1:0] goal1;
        logic [1:0]                         interp;
    } move_cmd_t;

    // Result payload, first field in the lowest bits.
    typedef struct packed {
        logic [2:0]                         status;
        logic signed [jti_pkg::ANGLE_W-1:0] sp3;
        logic signed [jti_pkg::ANGLE_W-1:0] sp2;
        logic signed [jti_pkg::ANGLE_W-1:0] sp1;
    } setpoints_t;

    // Stall patterns of the result receiver.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [jti_pkg::IN_DATA_W-1:0]     s_axis_tdata = '0;
    logic [0:0]                        s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [jti_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
    logic                              cfg_we = 1'b0;
    logic [jti_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [jti_pkg::ANGLE_W-1:0]       cfg_data = '0;

    // Shadow copy of the trajectory state and the joint limits.
    logic signed [jti_pkg::ANGLE_W-1:0] hold_pos[3];
    logic signed [jti_pkg::ANGLE_W-1:0] target_pos[3];
    logic signed [jti_pkg::ANGLE_W-1:0] joint_limit[4];
    int                                 tick_count;
    int                                 move_span;
    bit                                 blend_on;
    bit                                 in_motion;

    setpoints_t expected_setpoints[$];
    int         error_count = 0;
    int         report_count = 0;
    int         burst_left = 0;
    int         quiet_cycles = 0;
    logic [31:0] ready_cycle = '0;
    rx_mode_t   ready_mode = RX_ALWAYS;

    joint_trajectory_interpolator_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock generation.
    always #CLK_HALF aclk = ~aclk;

    // Rounded quotient p / t, ties going up.
    function automatic longint rounded_ratio(longint p, longint t);
        longint q;
        longint r;
        q = p / t;
        r = p % t;
        if (r >= t - r) begin
            q++;
        end
        return q;
    endfunction

    // Commanded position of one joint for the current shadow state.
    function automatic logic signed [jti_pkg::ANGLE_W-1:0] joint_setpoint(int j);
        longint s;
        longint g;
        longint d;
        longint m;
        longint t;
        longint e;
        longint u;
        longint a;
        longint q;
        bit     first_half;
        s = hold_pos[j];
        g = target_pos[j];
        d = g - s;
        m = (d < 0) ? -d : d;
        t = (move_span == 0) ? 1 : move_span;
        e = tick_count;
        if (!in_motion) begin
            return hold_pos[j];
        end
        if (!blend_on) begin
            q = rounded_ratio(m * e, t);
            return jti_pkg::ANGLE_W'((d < 0) ? s - q : s + q);
        end
        // Two parabolas: the first rises from the start, the second lands on the goal.
        first_half = (2 * e <= t);
        u = first_half ? e : t - e;
        a = (m * u) / t;
        q = rounded_ratio(2 * a * u, t);
        if (first_half) begin
            return jti_pkg::ANGLE_W'((d < 0) ? s - q : s + q);
        end
        return jti_pkg::ANGLE_W'((d < 0) ? g + q : g - q);
    endfunction

    // Advances the shadow state by one item and returns the setpoints it yields.
    function automatic setpoints_t step_trajectory(logic func, move_cmd_t cmd);
        setpoints_t res;
        logic [2:0] st;
        if (func == jti_pkg::FUNC_MOVE) begin
            if (in_motion) begin
                st = jti_pkg::STAT_BUSY;
            end else if ((cmd.interp != jti_pkg::INTERP_LINEAR &&
                          cmd.interp != jti_pkg::INTERP_BLEND) ||
                         cmd.goal2 < joint_limit[jti_pkg::REG_J2_LOW] ||
                         cmd.goal2 > joint_limit[jti_pkg::REG_J2_HIGH] ||
                         cmd.goal3 < joint_limit[jti_pkg::REG_J3_LOW] ||
                         cmd.goal3 > joint_limit[jti_pkg::REG_J3_HIGH] ||
                         cmd.ticks == '0) begin
                st = jti_pkg::STAT_BAD;
            end else begin
                target_pos[0] = cmd.goal1;
                target_pos[1] = cmd.goal2;
                target_pos[2] = cmd.goal3;
                move_span = int'(cmd.ticks);
                tick_count = 0;
                blend_on = (cmd.interp == jti_pkg::INTERP_BLEND);
                in_motion = 1'b1;
                st = jti_pkg::STAT_MOVING;
            end
        end else if (!in_motion) begin
            st = jti_pkg::STAT_HOLD;
        end else begin
            tick_count++;
            if (tick_count >= move_span) begin
                hold_pos = target_pos;
                in_motion = 1'b0;
                tick_count = 0;
                st = jti_pkg::STAT_FINISHED;
            end else begin
                st = jti_pkg::STAT_MOVING;
            end
        end
        res.sp1 = joint_setpoint(0);
        res.sp2 = joint_setpoint(1);
        res.sp3 = joint_setpoint(2);
        res.status = st;
        return res;
    endfunction

    function automatic move_cmd_t make_move(logic [1:0] interp, int g1, int g2, int g3,
                                            int ticks);
        move_cmd_t cmd;
        cmd.interp = interp;
        cmd.goal1 = jti_pkg::ANGLE_W'(g1);
        cmd.goal2 = jti_pkg::ANGLE_W'(g2);
        cmd.goal3 = jti_pkg::ANGLE_W'(g3);
        cmd.ticks = jti_pkg::TICK_W'(ticks);
        return cmd;
    endfunction

    function automatic move_cmd_t random_cmd();
        return make_move(2'($urandom), $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Value inside [lo, hi], often on an edge; anything when the range is empty.
    function automatic int pick_within(int lo, int hi);
        int r;
        r = $urandom_range(0, 9);
        if (lo > hi) begin
            return int'($urandom_range(0, 65535)) - 32768;
        end
        if (r == 0) begin
            return lo;
        end
        if (r == 1) begin
            return hi;
        end
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Sends one item in bursts with random gaps; the expectation is queued first.
    task automatic send_item(input logic func, input move_cmd_t cmd);
        int gap;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        expected_setpoints.insert(expected_setpoints.size(), step_trajectory(func, cmd));
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= jti_pkg::IN_DATA_W'(cmd);
        s_axis_tuser <= func;
        do @(posedge aclk); while (!s_axis_tready);
        burst_left--;
    endtask

    task automatic send_tick();
        send_item(jti_pkg::FUNC_TICK, random_cmd());
    endtask

    task automatic send_move(input logic [1:0] interp, input int g1, input int g2,
                             input int g3, input int ticks);
        send_item(jti_pkg::FUNC_MOVE, make_move(interp, g1, g2, g3, ticks));
    endtask

    // Stops the sender and waits until every expected result has arrived.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_setpoints.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [jti_pkg::CFG_IDX_W-1:0] index,
                               input logic signed [jti_pkg::ANGLE_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        joint_limit[index] = value;
        @(posedge aclk);
    endtask

    task automatic write_limits(input int j2_lo, input int j2_hi, input int j3_lo,
                                input int j3_hi);
        wait_idle();
        write_limit(jti_pkg::REG_J2_LOW, jti_pkg::ANGLE_W'(j2_lo));
        write_limit(jti_pkg::REG_J2_HIGH, jti_pkg::ANGLE_W'(j2_hi));
        write_limit(jti_pkg::REG_J3_LOW, jti_pkg::ANGLE_W'(j3_lo));
        write_limit(jti_pkg::REG_J3_HIGH, jti_pkg::ANGLE_W'(j3_hi));
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly well-formed moves followed by their ticks, with busy and bad commands mixed in.
    task automatic run_random(input int count);
        int        r;
        int        ticks;
        move_cmd_t cmd;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (in_motion) begin
                if (r < 88) begin
                    send_tick();
                end else begin
                    send_item(jti_pkg::FUNC_MOVE, random_cmd());
                end
            end else if (r < 70) begin
                r = $urandom_range(0, 99);
                ticks = (r < 85) ? $urandom_range(1, 16) :
                        (r < 97) ? $urandom_range(17, 64) : $urandom_range(65, 200);
                cmd = make_move(($urandom_range(0, 1) == 0) ? jti_pkg::INTERP_LINEAR :
                                                              jti_pkg::INTERP_BLEND,
                                ($urandom_range(0, 7) == 0) ?
                                    (($urandom_range(0, 1) == 0) ? -32768 : 32767) :
                                    int'($urandom_range(0, 65535)) - 32768,
                                pick_within(int'(joint_limit[jti_pkg::REG_J2_LOW]),
                                            int'(joint_limit[jti_pkg::REG_J2_HIGH])),
                                pick_within(int'(joint_limit[jti_pkg::REG_J3_LOW]),
                                            int'(joint_limit[jti_pkg::REG_J3_HIGH])),
                                ticks);
                send_item(jti_pkg::FUNC_MOVE, cmd);
            end else if (r < 82) begin
                cmd = random_cmd();
                if ($urandom_range(0, 3) == 0) begin
                    cmd.ticks = '0;
                end
                send_item(jti_pkg::FUNC_MOVE, cmd);
            end else begin
                send_tick();
            end
        end
    endtask

    // A tick while holding and every reason to reject a move, at the reset limits.
    task automatic test_holding_and_rejects();
        send_tick();
        send_move(INTERP_NONE, 100, 0, 0, 5);
        send_move(INTERP_RSVD, 100, 0, 0, 5);
        send_move(jti_pkg::INTERP_LINEAR, 100, 0, 0, 0);
        send_move(jti_pkg::INTERP_LINEAR, 100, int'(jti_pkg::J2_LOW_RESET) - 1, 0, 5);
        send_move(jti_pkg::INTERP_BLEND, 100, int'(jti_pkg::J2_HIGH_RESET) + 1, 0, 5);
        send_move(jti_pkg::INTERP_LINEAR, 100, 0, int'(jti_pkg::J3_LOW_RESET) - 1, 5);
        send_move(jti_pkg::INTERP_BLEND, 100, 0, int'(jti_pkg::J3_HIGH_RESET) + 1, 5);
    endtask

    // Linear move to the limit edges, a busy command inside it, then holding.
    task automatic test_linear_move();
        send_move(jti_pkg::INTERP_LINEAR, 32767, int'(jti_pkg::J2_LOW_RESET),
                  int'(jti_pkg::J3_HIGH_RESET), 3);
        send_move(INTERP_RSVD, -1, -1, -1, 65535);
        repeat (3) send_tick();
        send_tick();
    endtask

    // Blend moves across the whole angle range and a one-tick blend.
    task automatic test_blend_move();
        write_limits(-32768, 32767, -32768, 32767);
        send_move(jti_pkg::INTERP_BLEND, -32768, 32767, -32768, 4);
        repeat (4) send_tick();
        send_move(jti_pkg::INTERP_BLEND, 0, 0, 0, 1);
        send_tick();
    endtask

    task automatic test_random_reset_limits();
        write_limits(int'(jti_pkg::J2_LOW_RESET), int'(jti_pkg::J2_HIGH_RESET),
                     int'(jti_pkg::J3_LOW_RESET), int'(jti_pkg::J3_HIGH_RESET));
        run_random(120);
    endtask

    task automatic test_random_full_range();
        write_limits(-32768, 32767, -32768, 32767);
        run_random(100);
    endtask

    task automatic test_random_narrow_limits();
        int lo2;
        int lo3;
        lo2 = int'($urandom_range(0, 30000)) - 20000;
        lo3 = int'($urandom_range(0, 30000)) - 20000;
        write_limits(lo2, lo2 + int'($urandom_range(0, 8000)), lo3,
                     lo3 + int'($urandom_range(0, 8000)));
        run_random(80);
    endtask

    // Each joint limit collapses to a single allowed angle.
    task automatic test_random_pinned_limits();
        int v2;
        int v3;
        v2 = int'($urandom_range(0, 65535)) - 32768;
        v3 = int'($urandom_range(0, 65535)) - 32768;
        write_limits(v2, v2, v3, v3);
        run_random(50);
    endtask

    // Low above high: every move command must be rejected.
    task automatic test_random_inverted_limits();
        write_limits(32767, -32768, 32767, -32768);
        run_random(30);
    endtask

    // Main sequence.
    initial begin
        for (int j = 0; j < 3; j++) begin
            hold_pos[j] = '0;
            target_pos[j] = '0;
        end
        joint_limit[jti_pkg::REG_J2_LOW] = jti_pkg::J2_LOW_RESET;
        joint_limit[jti_pkg::REG_J2_HIGH] = jti_pkg::J2_HIGH_RESET;
        joint_limit[jti_pkg::REG_J3_LOW] = jti_pkg::J3_LOW_RESET;
        joint_limit[jti_pkg::REG_J3_HIGH] = jti_pkg::J3_HIGH_RESET;
        tick_count = 0;
        move_span = 0;
        blend_on = 1'b0;
        in_motion = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_holding_and_rejects();
        test_linear_move();
        test_blend_move();
        test_random_reset_limits();
        test_random_full_range();
        test_random_narrow_limits();
        test_random_pinned_limits();
        test_random_inverted_limits();

        wait_idle();
        repeat (END_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_setpoints.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Result receiver: a new stall pattern is drawn whenever the low eight counter bits are zero.
    always @(posedge aclk) begin
        ready_cycle <= ready_cycle + 1;
        if (ready_cycle[7:0] == 8'd0) begin
            ready_mode <= rx_mode_t'($urandom_range(0, 3));
        end
        case (ready_mode)
            RX_ALWAYS: begin
                m_axis_tready <= 1'b1;
            end
            RX_COIN: begin
                m_axis_tready <= ($urandom_range(0, 1) == 1);
            end
            RX_SPARSE: begin
                m_axis_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_axis_tready <= (ready_cycle[2:0] != 3'd7);
            end
        endcase
    end

    // Compares each result transfer with the oldest expectation.
    always @(posedge aclk) begin
        setpoints_t got;
        setpoints_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[jti_pkg::OUT_BITS-1:0];
            if (expected_setpoints.size() == 0) begin
                error_count++;
                if (report_count < REPORT_LIMIT) begin
                    $display("unexpected result: sp %0d %0d %0d status %0d",
                             got.sp1, got.sp2, got.sp3, got.status);
                end
                report_count++;
            end else begin
                want = expected_setpoints.pop_front();
                if (got.sp1 != want.sp1 || got.sp2 != want.sp2 || got.sp3 != want.sp3 ||
                    got.status != want.status) begin
                    error_count++;
                    if (report_count < REPORT_LIMIT) begin
                        $display("mismatch: want %0d %0d %0d st %0d, got %0d %0d %0d st %0d",
                                 want.sp1, want.sp2, want.sp3, want.status,
                                 got.sp1, got.sp2, got.sp3, got.status);
                    end
                    report_count++;
                end
            end
        end
    end

    // Counts cycles without any transfer on either stream.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: ends a run that has stopped making progress.
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- joint_trajectory_interpolator_unit.f -----
sv/jti_pkg.sv
sv/jti_muldiv.sv
sv/joint_trajectory_interpolator_unit.sv
dv/testbench.sv
